[hdl/lowest_free_seat_allocator_unit_macros.svh]
// Assertion macros shared by the seat allocator RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef LOWEST_FREE_SEAT_ALLOCATOR_UNIT_MACROS_SVH
`define LOWEST_FREE_SEAT_ALLOCATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked once reset is released.
`define LFSA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("seat allocator: same-cycle check failed");

// Next-cycle implication, checked once reset is released.
`define LFSA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("seat allocator: next-cycle check failed");

`endif

[hdl/lfsa_pkg.sv]
`default_nettype none

package lfsa_pkg;

	localparam int TIME_FIELD_W = 20;
	localparam int SEAT_IDX_W   = 6;

	typedef struct packed {
		logic [TIME_FIELD_W-1:0] arrival_time;
		logic [TIME_FIELD_W-1:0] leave_time;
	} req_word_t;

	typedef struct packed {
		logic [SEAT_IDX_W-1:0] seat_index;
		logic                  none_free;
	} rsp_word_t;

	// Commands broadcast from the sequencer to every seat cell.
	typedef struct packed {
		logic release_check;
		logic grant;
	} cell_ctl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_GRANT,
		ST_HOLD
	} alloc_state_t;

endpackage

`default_nettype wire

[hdl/lfsa_cell.sv]
`default_nettype none

module lfsa_cell #(
	parameter int TIME_BITS = 20
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire lfsa_pkg::cell_ctl_t  ctl,
	input  wire logic [TIME_BITS-1:0] arrival,
	input  wire logic [TIME_BITS-1:0] leave,
	input  wire logic                 found_in,
	output logic                      found_out,
	output logic                      take
);
	import lfsa_pkg::*;

	logic                 busy_q;
	logic [TIME_BITS-1:0] release_q;
	logic                 free;

	// A free seat claims the grant unless a lower neighbour has already done so.
	assign free      = !busy_q;
	assign take      = free && !found_in;
	assign found_out = found_in || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (ctl.release_check && busy_q && (release_q <= arrival)) begin
			busy_q <= 1'b0;
		end else if (ctl.grant && take) begin
			busy_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.grant && take) begin
			release_q <= leave;
		end
	end

endmodule

`default_nettype wire

[hdl/lfsa_enc.sv]
`default_nettype none

module lfsa_enc #(
	parameter int SEAT_COUNT = 64
) (
	input  wire logic [SEAT_COUNT-1:0] grant,
	input  wire logic                  none_free,
	output lfsa_pkg::rsp_word_t        word
);
	import lfsa_pkg::*;

	logic [SEAT_IDX_W-1:0] idx;

	// The grant vector is one-hot or empty, so an OR of the seat numbers encodes it.
	always_comb begin
		idx = '0;
		for (int s = 0; s < SEAT_COUNT; s++) begin
			if (grant[s]) begin
				idx = idx | SEAT_IDX_W'(s);
			end
		end
		word.seat_index = idx;
		word.none_free  = none_free;
	end

endmodule

`default_nettype wire

[hdl/lowest_free_seat_allocator_unit.sv]
// Lowest free seat allocator.
// The req channel carries one word per request: an arrival time and a leave time,
// with arrival times expected in nondecreasing order. The rsp channel returns one
// word per request: the lowest-numbered seat granted, or none_free set (and seat
// index zero) when every seat is still occupied.
// Both channels use valid and stall; a word moves at a rising edge with valid
// high and stall low.
// At the accepting edge every occupied seat whose release time is at or before
// the arrival is freed. In the following cycle the seat cells pick and claim the
// lowest free seat, and the grant is registered. The result word is then loaded
// into the output register once that register is free, which raises rsp_valid.
// A new request is taken while idle or at the same edge at which the previous
// result is loaded, so no request is accepted during a grant pass; the free and
// grant passes run through the row of seat cells.
// When rsp is stalled the finished result waits in the output register and the
// next request may still be accepted and processed; it then holds until the
// output register empties.
// Reset clears every occupancy flag at once, so all seats are free right after
// reset and requests may be accepted as soon as reset is released.

`default_nettype none

`include "lowest_free_seat_allocator_unit_macros.svh"

module lowest_free_seat_allocator_unit #(
	parameter int SEAT_COUNT = 64,
	parameter int TIME_BITS  = 20
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                req_valid,
	output logic                     req_stall,
	input  wire lfsa_pkg::req_word_t req,
	output logic                     rsp_valid,
	input  wire logic                rsp_stall,
	output lfsa_pkg::rsp_word_t      rsp
);
	import lfsa_pkg::*;

	alloc_state_t          state_q;
	alloc_state_t          state_d;

	logic                  req_acc;
	logic                  slot_free;
	logic                  load_rsp;

	// Request fields reduced or extended to the internal time width.
	logic [TIME_BITS-1:0]  arrival;
	logic [TIME_BITS-1:0]  leave_q;

	cell_ctl_t             ctl;
	logic [SEAT_COUNT:0]   found;
	logic [SEAT_COUNT-1:0] take;

	// Snapshot of the grant pass, encoded in the following cycle.
	logic [SEAT_COUNT-1:0] grant_q;
	logic                  none_free_q;

	rsp_word_t             enc_word;
	logic                  rsp_valid_q;
	rsp_word_t             rsp_q;

	assign arrival   = TIME_BITS'(req.arrival_time);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign load_rsp  = (state_q == ST_HOLD) && slot_free;
	assign req_stall = !((state_q == ST_IDLE) || load_rsp);
	assign req_acc   = req_valid && !req_stall;

	// The free pass runs at the accepting edge; the grant pass in the following cycle.
	assign ctl.release_check = req_acc;
	assign ctl.grant         = (state_q == ST_GRANT);

	// The found chain ripples upward from seat zero; the first free seat wins.
	assign found[0] = 1'b0;

	for (genvar s = 0; s < SEAT_COUNT; s++) begin : g_seat
		lfsa_cell #(
			.TIME_BITS(TIME_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.arrival  (arrival),
			.leave    (leave_q),
			.found_in (found[s]),
			.found_out(found[s+1]),
			.take     (take[s])
		);
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			leave_q <= TIME_BITS'(req.leave_time);
		end
		if (state_q == ST_GRANT) begin
			grant_q     <= take;
			none_free_q <= !found[SEAT_COUNT];
		end
	end

	lfsa_enc #(
		.SEAT_COUNT(SEAT_COUNT)
	) u_enc (
		.grant    (grant_q),
		.none_free(none_free_q),
		.word     (enc_word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_acc) begin
					state_d = ST_GRANT;
				end
			end
			ST_GRANT: begin
				state_d = ST_HOLD;
			end
			ST_HOLD: begin
				if (slot_free) begin
					state_d = req_acc ? ST_GRANT : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// The output register keeps a finished word until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_rsp) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rsp) begin
			rsp_q <= enc_word;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// A granted word carries exactly one seat, a refused one carries none.
	`LFSA_ASSERT_NOW(a_grant_shape, state_q == ST_HOLD, none_free_q ? (grant_q == '0) : $onehot(grant_q))
	// Every accepted request goes straight into its grant pass.
	`LFSA_ASSERT_NEXT(a_acc_to_grant, req_acc, state_q == ST_GRANT)
	// A result loaded into a free output slot is offered in the next cycle.
	`LFSA_ASSERT_NEXT(a_load_shows, load_rsp, rsp_valid)

endmodule

`default_nettype wire
